// ===== rtl/core/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg - shared definitions for the two-channel converter smoother
// Widths, register indexes, reset weights and the sequencer phase type.
// ----------------------------------------------------------------------------
package acs_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int WEIGHT_BITS     = 16;
   localparam int LEVEL_BITS      = 26;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIGHT_WEIGHT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEMP_WEIGHT  = 2'd1;

   localparam logic [WEIGHT_BITS-1:0] LIGHT_WEIGHT_RST = 16'd1311;
   localparam logic [WEIGHT_BITS-1:0] TEMP_WEIGHT_RST  = 16'd131;

   localparam logic CH_LIGHT = 1'b0;
   localparam logic CH_TEMP  = 1'b1;

   typedef enum logic [3:0] {
      PH_LIGHT_DROP = 4'b0001,
      PH_LIGHT_USE  = 4'b0010,
      PH_TEMP_DROP  = 4'b0100,
      PH_TEMP_USE   = 4'b1000
   } phase_type;

endpackage

// ===== rtl/core/acs_ema.sv =====
// ----------------------------------------------------------------------------
// acs_ema - one exponential moving average update step
// acc + floor(weight * ((x << FRAC_BITS) - acc) / 2^WEIGHT_BITS); a zero
// accumulator loads the scaled sample directly.
// ----------------------------------------------------------------------------
module acs_ema #(
   parameter int SAMPLE_BITS = acs_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = acs_pkg::FRAC_BITS_DEF
) (
   input  logic [SAMPLE_BITS-1:0]           sample,
   input  logic [SAMPLE_BITS+FRAC_BITS-1:0] acc,
   input  logic [acs_pkg::WEIGHT_BITS-1:0]  weight,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0] acc_next
);
   import acs_pkg::*;

   localparam int ACC_BITS = SAMPLE_BITS + FRAC_BITS;
   localparam int PROD_W   = WEIGHT_BITS + ACC_BITS;
   localparam logic [PROD_W-1:0] ROUND_UP = PROD_W'({WEIGHT_BITS{1'b1}});

   logic [ACC_BITS-1:0] target;
   logic                rising;
   logic [ACC_BITS-1:0] diff;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]   prod_adj;
   logic [ACC_BITS-1:0] step;
   logic [ACC_BITS:0]   sum;

   assign target   = {sample, {FRAC_BITS{1'b0}}};
   assign rising   = (target >= acc);
   assign diff     = rising ? (target - acc) : (acc - target);
   assign prod     = PROD_W'(weight) * PROD_W'(diff);
   // falling side: round the magnitude up so the shift floors toward minus infinity
   assign prod_adj = rising ? prod : (prod + ROUND_UP);
   assign step     = prod_adj[PROD_W-1:WEIGHT_BITS];
   assign sum      = {1'b0, acc} + {1'b0, step};

   always_comb begin
      if (acc == '0) begin
         acc_next = target;
      end else if (rising) begin
         acc_next = sum[ACC_BITS-1:0];
      end else if (step >= acc) begin
         acc_next = '0;
      end else begin
         acc_next = acc - step;
      end
   end

endmodule

// ===== rtl/core/adc_two_channel_smoother.sv =====
// ----------------------------------------------------------------------------
// adc_two_channel_smoother - converter sequencer with per-channel smoothing
// Alternates light and temperature channels, drops the first sample after
// each switch and runs an exponential moving average on the second.
// ----------------------------------------------------------------------------
// Usage: each req beat carries one raw converter sample and yields exactly
// one rsp beat with the channel to select next, a used flag and both filtered
// levels (16 fraction bits). The block takes one beat per cycle while the
// result register is free or taken (rsp_ready); a beat waits in the input
// register, then the multiply-add of the smoothing unit updates the
// accumulator as it moves into the result register. The phase sequence after
// reset is light drop, light use, temperature drop, temperature use. Write the weights
// on the csr channel only while no beat is in flight; indexes past the
// register list are ignored.
module adc_two_channel_smoother #(
   parameter int SAMPLE_BITS = acs_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = acs_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_next_channel,
   output logic                                 rsp_sample_used,
   output logic [acs_pkg::LEVEL_BITS-1:0]       rsp_light_level,
   output logic [acs_pkg::LEVEL_BITS-1:0]       rsp_temp_level,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [acs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [acs_pkg::WEIGHT_BITS-1:0]      csr_wdata
);
   import acs_pkg::*;

   localparam int ACC_BITS = SAMPLE_BITS + FRAC_BITS;

   logic [WEIGHT_BITS-1:0] light_weight_ff, light_weight_in;
   logic [WEIGHT_BITS-1:0] temp_weight_ff, temp_weight_in;

   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;

   phase_type              phase_ff, phase_in;
   logic [ACC_BITS-1:0]    light_acc_ff, light_acc_in;
   logic [ACC_BITS-1:0]    temp_acc_ff, temp_acc_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_next_channel_ff, rsp_next_channel_in;
   logic                   rsp_sample_used_ff, rsp_sample_used_in;
   logic [LEVEL_BITS-1:0]  rsp_light_level_ff, rsp_light_level_in;
   logic [LEVEL_BITS-1:0]  rsp_temp_level_ff, rsp_temp_level_in;

   logic                   advance;
   logic                   req_fire;
   logic                   use_temp;
   logic [ACC_BITS-1:0]    ema_acc;
   logic [WEIGHT_BITS-1:0] ema_weight;
   logic [ACC_BITS-1:0]    ema_next;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      light_weight_in = light_weight_ff;
      temp_weight_in  = temp_weight_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LIGHT_WEIGHT: light_weight_in = csr_wdata;
            CSR_TEMP_WEIGHT:  temp_weight_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      if (req_fire) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_sample;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // one shared smoothing unit, steered by the phase
   assign use_temp   = (phase_ff == PH_TEMP_USE);
   assign ema_acc    = use_temp ? temp_acc_ff : light_acc_ff;
   assign ema_weight = use_temp ? temp_weight_ff : light_weight_ff;

   acs_ema #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_ema (
      .sample   (in_sample_ff),
      .acc      (ema_acc),
      .weight   (ema_weight),
      .acc_next (ema_next)
   );

   always_comb begin
      phase_in            = phase_ff;
      light_acc_in        = light_acc_ff;
      temp_acc_in         = temp_acc_ff;
      rsp_next_channel_in = rsp_next_channel_ff;
      rsp_sample_used_in  = rsp_sample_used_ff;
      rsp_valid_in        = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         case (phase_ff)
            PH_LIGHT_DROP: begin
               rsp_next_channel_in = CH_LIGHT;
               rsp_sample_used_in  = 1'b0;
               phase_in            = PH_LIGHT_USE;
            end
            PH_LIGHT_USE: begin
               light_acc_in        = ema_next;
               rsp_next_channel_in = CH_TEMP;
               rsp_sample_used_in  = 1'b1;
               phase_in            = PH_TEMP_DROP;
            end
            PH_TEMP_DROP: begin
               rsp_next_channel_in = CH_TEMP;
               rsp_sample_used_in  = 1'b0;
               phase_in            = PH_TEMP_USE;
            end
            PH_TEMP_USE: begin
               temp_acc_in         = ema_next;
               rsp_next_channel_in = CH_LIGHT;
               rsp_sample_used_in  = 1'b1;
               phase_in            = PH_LIGHT_DROP;
            end
            default: begin
               rsp_next_channel_in = CH_LIGHT;
               rsp_sample_used_in  = 1'b0;
               phase_in            = PH_LIGHT_DROP;
            end
         endcase
      end
      rsp_light_level_in = advance ? LEVEL_BITS'(light_acc_in) : rsp_light_level_ff;
      rsp_temp_level_in  = advance ? LEVEL_BITS'(temp_acc_in) : rsp_temp_level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_weight_ff <= LIGHT_WEIGHT_RST;
         temp_weight_ff  <= TEMP_WEIGHT_RST;
         in_valid_ff     <= 1'b0;
         phase_ff        <= PH_LIGHT_DROP;
         light_acc_ff    <= '0;
         temp_acc_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         light_weight_ff <= light_weight_in;
         temp_weight_ff  <= temp_weight_in;
         in_valid_ff     <= in_valid_in;
         phase_ff        <= phase_in;
         light_acc_ff    <= light_acc_in;
         temp_acc_ff     <= temp_acc_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff        <= in_sample_in;
      rsp_next_channel_ff <= rsp_next_channel_in;
      rsp_sample_used_ff  <= rsp_sample_used_in;
      rsp_light_level_ff  <= rsp_light_level_in;
      rsp_temp_level_ff   <= rsp_temp_level_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_channel = rsp_next_channel_ff;
   assign rsp_sample_used  = rsp_sample_used_ff;
   assign rsp_light_level  = rsp_light_level_ff;
   assign rsp_temp_level   = rsp_temp_level_ff;

endmodule
